// ===== design/fixed_page_allocator_defines.svh =====
// Assertion macros used by the allocator top level.
`ifndef FIXED_PAGE_ALLOCATOR_DEFINES_SVH
`define FIXED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fpa_pkg.sv =====
package fpa_pkg;

	localparam int PAGES_DEF      = 256;
	localparam int PAGE_BYTES_DEF = 256;

	// free-page search looks at this many pages per cycle
	localparam int SCAN_W = 8;
	localparam int SBW    = $clog2(SCAN_W);

	localparam int OP_W    = 2;
	localparam int PNUM_W  = 10;
	localparam int LEN_W   = 10;
	localparam int OFS_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 4;
	localparam int APAGE_W = 8;
	localparam int CSIZE_W = 9;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK          = 4'd0;
	localparam logic [STAT_W-1:0] STAT_NO_PAGE     = 4'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_LEN     = 4'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE       = 4'd3;
	localparam logic [STAT_W-1:0] STAT_READ_SHORT  = 4'd4;
	localparam logic [STAT_W-1:0] STAT_READ_FREE   = 4'd5;
	localparam logic [STAT_W-1:0] STAT_WRITE_LONG  = 4'd6;
	localparam logic [STAT_W-1:0] STAT_WRITE_FREE  = 4'd7;
	localparam logic [STAT_W-1:0] STAT_OFFSET      = 4'd8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CLEAR,
		S_CHECK,
		S_RDATA,
		S_FINISH
	} fpa_state_t;

	typedef struct packed {
		logic lookup;
		logic scan;
		logic claim;
		logic drop;
	} pt_ctrl_t;

	typedef struct packed {
		logic used;
		logic full;
		logic found;
	} pt_stat_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} bs_ctrl_t;

endpackage

// ===== design/fixed_page_allocator.sv =====
// Path to a result: a read goes through the check and read-data states; write, free and
// failed checks through the check state; allocate count/length failures and page range
// errors go straight to finish. Allocate time is set by the byte-at-a-time zero sweep of
// the new page and the 8-pages-per-cycle free search. One transaction at a time: the next
// is taken the cycle after the result is registered.
// Reset marks every page free and the in-use count zero; page bytes are not cleared.
module fixed_page_allocator #(
	parameter int PAGES      = fpa_pkg::PAGES_DEF,
	parameter int PAGE_BYTES = fpa_pkg::PAGE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fpa_pkg::OP_W-1:0]    operation,
	input  logic signed [fpa_pkg::PNUM_W-1:0] page_number,
	input  logic [fpa_pkg::LEN_W-1:0]   transfer_length,
	input  logic [fpa_pkg::OFS_W-1:0]   byte_offset,
	input  logic [fpa_pkg::BYTE_W-1:0]  write_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fpa_pkg::STAT_W-1:0]  status,
	output logic [fpa_pkg::APAGE_W-1:0] allocated_page,
	output logic [fpa_pkg::BYTE_W-1:0]  read_byte,
	output logic [fpa_pkg::CSIZE_W-1:0] current_size
);

	`include "fixed_page_allocator_defines.svh"

	localparam int PW  = $clog2(PAGES);
	localparam int SZW = $clog2(PAGE_BYTES + 1);
	localparam int BAW = $clog2(PAGES * PAGE_BYTES);

	fpa_pkg::fpa_state_t state_q, state_d;

	logic [fpa_pkg::OP_W-1:0]    op_q;
	logic [fpa_pkg::LEN_W-1:0]   len_q;
	logic [fpa_pkg::OFS_W-1:0]   ofs_q;
	logic [fpa_pkg::BYTE_W-1:0]  wbyte_q;
	logic [PW-1:0]               page_q;
	logic [BAW-1:0]              addr_q;

	logic [fpa_pkg::STAT_W-1:0]  res_status_q;
	logic [fpa_pkg::APAGE_W-1:0] res_page_q;
	logic [fpa_pkg::BYTE_W-1:0]  res_rd_q;
	logic [fpa_pkg::CSIZE_W-1:0] res_size_q;

	logic                        out_valid_q;
	logic [fpa_pkg::STAT_W-1:0]  status_q;
	logic [fpa_pkg::APAGE_W-1:0] allocated_page_q;
	logic [fpa_pkg::BYTE_W-1:0]  read_byte_q;
	logic [fpa_pkg::CSIZE_W-1:0] current_size_q;

	fpa_pkg::pt_ctrl_t           pt_ctrl;
	fpa_pkg::pt_stat_t           pt_stat;
	fpa_pkg::bs_ctrl_t           bs_ctrl;
	logic [PW-1:0]               pt_page;
	logic [SZW-1:0]              size_rd;
	logic [PW-1:0]               found_page;
	logic [fpa_pkg::BYTE_W-1:0]  bs_rdata;
	logic                        bs_busy;

	logic                        accept;
	logic                        in_range;
	logic                        bad_len;
	logic [fpa_pkg::STAT_W-1:0]  acc_status;
	logic [SZW-1:0]              sz_cur;
	logic [fpa_pkg::STAT_W-1:0]  chk_status;
	logic                        out_load;

	assign in_stall = (state_q != fpa_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = !out_valid_q || !out_stall;

	always_comb begin
		in_range = !page_number[fpa_pkg::PNUM_W-1]
			&& ((fpa_pkg::PNUM_W+1)'(page_number[fpa_pkg::PNUM_W-2:0])
				< (fpa_pkg::PNUM_W+1)'(PAGES));
		bad_len  = (transfer_length == '0) || (32'(transfer_length) > 32'(PAGE_BYTES));
		if (operation == fpa_pkg::OP_ALLOC) begin
			if (pt_stat.full)
				acc_status = fpa_pkg::STAT_NO_PAGE;
			else if (bad_len)
				acc_status = fpa_pkg::STAT_BAD_LEN;
			else
				acc_status = fpa_pkg::STAT_OK;
		end else begin
			acc_status = in_range ? fpa_pkg::STAT_OK : fpa_pkg::STAT_RANGE;
		end
	end

	// size memory holds stale sizes of freed pages: gate with the in-use bit
	always_comb begin
		sz_cur = pt_stat.used ? size_rd : '0;
		case (op_q)
			fpa_pkg::OP_READ: begin
				if (sz_cur == '0)
					chk_status = fpa_pkg::STAT_READ_FREE;
				else if (32'(len_q) < 32'(sz_cur))
					chk_status = fpa_pkg::STAT_READ_SHORT;
				else if (32'(ofs_q) >= 32'(sz_cur))
					chk_status = fpa_pkg::STAT_OFFSET;
				else
					chk_status = fpa_pkg::STAT_OK;
			end
			fpa_pkg::OP_WRITE: begin
				if (sz_cur == '0)
					chk_status = fpa_pkg::STAT_WRITE_FREE;
				else if (32'(len_q) > 32'(sz_cur))
					chk_status = fpa_pkg::STAT_WRITE_LONG;
				else if (32'(ofs_q) >= 32'(sz_cur))
					chk_status = fpa_pkg::STAT_OFFSET;
				else
					chk_status = fpa_pkg::STAT_OK;
			end
			default: chk_status = fpa_pkg::STAT_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		pt_ctrl = '0;
		bs_ctrl = '0;
		pt_page = page_q;
		case (state_q)
			fpa_pkg::S_IDLE: begin
				pt_page = page_number[PW-1:0];
				if (in_valid) begin
					if (acc_status != fpa_pkg::STAT_OK) begin
						state_d = fpa_pkg::S_FINISH;
					end else if (operation == fpa_pkg::OP_ALLOC) begin
						pt_ctrl.scan = 1'b1;
						state_d      = fpa_pkg::S_SCAN;
					end else begin
						pt_ctrl.lookup = 1'b1;
						state_d        = fpa_pkg::S_CHECK;
					end
				end
			end
			fpa_pkg::S_SCAN: begin
				if (pt_stat.found) begin
					bs_ctrl.clr = 1'b1;
					state_d     = fpa_pkg::S_CLEAR;
				end
			end
			fpa_pkg::S_CLEAR: begin
				if (!bs_busy) begin
					pt_ctrl.claim = 1'b1;
					state_d       = fpa_pkg::S_FINISH;
				end
			end
			fpa_pkg::S_CHECK: begin
				state_d = fpa_pkg::S_FINISH;
				if (chk_status == fpa_pkg::STAT_OK) begin
					case (op_q)
						fpa_pkg::OP_READ: begin
							bs_ctrl.rd = 1'b1;
							state_d    = fpa_pkg::S_RDATA;
						end
						fpa_pkg::OP_WRITE: bs_ctrl.wr = 1'b1;
						fpa_pkg::OP_FREE:  pt_ctrl.drop = (sz_cur != '0);
						default: ;
					endcase
				end
			end
			fpa_pkg::S_RDATA: state_d = fpa_pkg::S_FINISH;
			fpa_pkg::S_FINISH: begin
				if (out_load)
					state_d = fpa_pkg::S_IDLE;
			end
			default: state_d = fpa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpa_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fpa_pkg::S_FINISH && out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= operation;
			len_q        <= transfer_length;
			ofs_q        <= byte_offset;
			wbyte_q      <= write_byte;
			page_q       <= page_number[PW-1:0];
			addr_q       <= BAW'(int'(page_number[PW-1:0]) * PAGE_BYTES + int'(byte_offset));
			res_status_q <= acc_status;
			res_page_q   <= '0;
			res_rd_q     <= '0;
			res_size_q   <= '0;
		end
		if (state_q == fpa_pkg::S_CLEAR && !bs_busy) begin
			res_page_q <= fpa_pkg::APAGE_W'(found_page);
			res_size_q <= fpa_pkg::CSIZE_W'(len_q);
		end
		if (state_q == fpa_pkg::S_CHECK) begin
			res_status_q <= chk_status;
			res_size_q   <= (op_q == fpa_pkg::OP_FREE) ? '0 : fpa_pkg::CSIZE_W'(sz_cur);
		end
		if (state_q == fpa_pkg::S_RDATA)
			res_rd_q <= bs_rdata;
		if (state_q == fpa_pkg::S_FINISH && out_load) begin
			status_q         <= res_status_q;
			allocated_page_q <= res_page_q;
			read_byte_q      <= res_rd_q;
			current_size_q   <= res_size_q;
		end
	end

	fpa_page_table #(
		.PAGES      (PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (pt_ctrl),
		.page       (pt_page),
		.claim_len  (SZW'(len_q)),
		.stat       (pt_stat),
		.size_rd    (size_rd),
		.found_page (found_page)
	);

	fpa_byte_store #(
		.PAGES      (PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (bs_ctrl),
		.addr     (addr_q),
		.wdata    (wbyte_q),
		.clr_page (found_page),
		.rdata    (bs_rdata),
		.busy     (bs_busy)
	);

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign allocated_page = allocated_page_q;
	assign read_byte      = read_byte_q;
	assign current_size   = current_size_q;

	`FPA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != fpa_pkg::S_IDLE, "accepted transaction left state idle")
	`FPA_ASSERT_NOW(a_scan_has_room, state_q == fpa_pkg::S_SCAN, !pt_stat.full, "free search started with no free page")
	`FPA_ASSERT_NOW(a_fail_zero, out_valid && status != fpa_pkg::STAT_OK, allocated_page == '0 && read_byte == '0, "failed result carries data")

endmodule

// ===== design/fpa_page_table.sv =====
module fpa_page_table #(
	parameter int PAGES      = fpa_pkg::PAGES_DEF,
	parameter int PAGE_BYTES = fpa_pkg::PAGE_BYTES_DEF,
	localparam int PW  = $clog2(PAGES),
	localparam int SZW = $clog2(PAGE_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fpa_pkg::pt_ctrl_t ctrl,
	input  logic [PW-1:0]     page,
	input  logic [SZW-1:0]    claim_len,
	output fpa_pkg::pt_stat_t stat,
	output logic [SZW-1:0]    size_rd,
	output logic [PW-1:0]     found_page
);

	localparam int CW  = $clog2(PAGES + 1);
	localparam int NCH = (PAGES + fpa_pkg::SCAN_W - 1) / fpa_pkg::SCAN_W;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int UW  = NCH * fpa_pkg::SCAN_W;

	logic [SZW-1:0]           size_mem [PAGES];
	logic [SZW-1:0]           size_rd_q;
	logic                     used_rd_q;
	logic [UW-1:0]            used_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     found_q;
	logic [CHW-1:0]           chunk_q;
	logic [PW-1:0]            found_page_q;

	logic [CHW-1:0]             chunk_idx;
	logic [fpa_pkg::SBW-1:0]    bit_sel;
	logic [fpa_pkg::SCAN_W-1:0] chunk;
	logic                       hit;
	logic [fpa_pkg::SBW-1:0]    hit_bit;

	// one read port on the in-use bitmap: search cursor while scanning, else the page
	always_comb begin
		chunk_idx = busy_q ? chunk_q : CHW'(page >> fpa_pkg::SBW);
		bit_sel   = fpa_pkg::SBW'(page);
		chunk     = used_q[chunk_idx*fpa_pkg::SCAN_W +: fpa_pkg::SCAN_W];
	end

	// lowest free page within the chunk, skipping pad bits past the last page
	always_comb begin
		hit     = 1'b0;
		hit_bit = '0;
		for (int i = fpa_pkg::SCAN_W - 1; i >= 0; i--) begin
			if (!chunk[i] && (int'(chunk_idx) * fpa_pkg::SCAN_W + i < PAGES)) begin
				hit     = 1'b1;
				hit_bit = fpa_pkg::SBW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			found_q <= 1'b0;
			chunk_q <= '0;
		end else begin
			if (ctrl.scan) begin
				busy_q  <= 1'b1;
				found_q <= 1'b0;
				chunk_q <= '0;
			end else if (busy_q) begin
				if (hit) begin
					busy_q  <= 1'b0;
					found_q <= 1'b1;
				end else begin
					chunk_q <= chunk_q + 1'b1;
				end
			end
			if (ctrl.claim) begin
				used_q[found_page_q] <= 1'b1;
				cnt_q                <= cnt_q + 1'b1;
			end else if (ctrl.drop) begin
				used_q[page] <= 1'b0;
				cnt_q        <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && hit && !ctrl.scan)
			found_page_q <= PW'(int'(chunk_q) * fpa_pkg::SCAN_W + int'(hit_bit));
		if (ctrl.lookup)
			used_rd_q <= chunk[bit_sel];
	end

	always_ff @(posedge clk) begin
		if (ctrl.claim)
			size_mem[found_page_q] <= claim_len;
		if (ctrl.lookup)
			size_rd_q <= size_mem[page];
	end

	assign stat.used  = used_rd_q;
	assign stat.full  = (cnt_q >= CW'(PAGES));
	assign stat.found = found_q;
	assign size_rd    = size_rd_q;
	assign found_page = found_page_q;

endmodule

// ===== design/fpa_byte_store.sv =====
module fpa_byte_store #(
	parameter int PAGES      = fpa_pkg::PAGES_DEF,
	parameter int PAGE_BYTES = fpa_pkg::PAGE_BYTES_DEF,
	localparam int PW  = $clog2(PAGES),
	localparam int BAW = $clog2(PAGES * PAGE_BYTES)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fpa_pkg::bs_ctrl_t          ctrl,
	input  logic [BAW-1:0]             addr,
	input  logic [fpa_pkg::BYTE_W-1:0] wdata,
	input  logic [PW-1:0]              clr_page,
	output logic [fpa_pkg::BYTE_W-1:0] rdata,
	output logic                       busy
);

	logic [fpa_pkg::BYTE_W-1:0] mem [PAGES * PAGE_BYTES];
	logic [fpa_pkg::BYTE_W-1:0] rdata_q;
	logic [BAW-1:0]             clr_addr_q;
	logic [BAW-1:0]             clr_last_q;
	logic                       busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctrl.clr) begin
			busy_q <= 1'b1;
		end else if (busy_q && (clr_addr_q == clr_last_q)) begin
			busy_q <= 1'b0;
		end
	end

	// sweep the claimed page, one byte a cycle
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			clr_addr_q <= BAW'(int'(clr_page) * PAGE_BYTES);
			clr_last_q <= BAW'(int'(clr_page) * PAGE_BYTES + PAGE_BYTES - 1);
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_addr_q] <= '0;
		else if (ctrl.wr)
			mem[addr] <= wdata;
		if (ctrl.rd)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule
